// ===== design/video_chip_register_file_macros.svh =====
// Assertion macros for the video chip register file.
// Depends on nothing; included by the top level only.
`ifndef VIDEO_CHIP_REGISTER_FILE_MACROS_SVH
`define VIDEO_CHIP_REGISTER_FILE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VCRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VCRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VCRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define VCRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/vcrf_pkg.sv =====
// Shared types, register addresses and defaults for the video chip register file.
// Used by vcrf_bank and video_chip_register_file.
package vcrf_pkg;

    localparam int SPRITES            = 8;
    localparam int SPR_IDX_W          = $clog2(SPRITES);
    localparam int FIRST_BAD_LINE_DEF = 48;
    localparam int LAST_BAD_LINE_DEF  = 247;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [5:0] ADDR_SPR_FIRST    = 6'h00;
    localparam logic [5:0] ADDR_SPR_LAST     = 6'h0F;
    localparam logic [5:0] ADDR_SPR_XHI      = 6'h10;
    localparam logic [5:0] ADDR_CTRL1        = 6'h11;
    localparam logic [5:0] ADDR_RASTER       = 6'h12;
    localparam logic [5:0] ADDR_PEN_X        = 6'h13;
    localparam logic [5:0] ADDR_PEN_Y        = 6'h14;
    localparam logic [5:0] ADDR_SPR_EN       = 6'h15;
    localparam logic [5:0] ADDR_CTRL2        = 6'h16;
    localparam logic [5:0] ADDR_SPR_YEXP     = 6'h17;
    localparam logic [5:0] ADDR_MEM_PTR      = 6'h18;
    localparam logic [5:0] ADDR_IRQ_FLAGS    = 6'h19;
    localparam logic [5:0] ADDR_IRQ_MASK     = 6'h1A;
    localparam logic [5:0] ADDR_SPR_PRIO     = 6'h1B;
    localparam logic [5:0] ADDR_SPR_MCOL     = 6'h1C;
    localparam logic [5:0] ADDR_SPR_XEXP     = 6'h1D;
    localparam logic [5:0] ADDR_SPR_SCOL     = 6'h1E;
    localparam logic [5:0] ADDR_SPR_DCOL     = 6'h1F;
    localparam logic [5:0] ADDR_SHARED_FIRST = 6'h20;
    localparam logic [5:0] ADDR_SHARED_LAST  = 6'h26;
    localparam logic [5:0] ADDR_SCOLOR_FIRST = 6'h27;
    localparam logic [5:0] ADDR_SCOLOR_LAST  = 6'h2E;

    localparam logic [7:0] UNUSED_READ = 8'hFF;

    typedef struct packed {
        logic       wr;
        logic [5:0] addr;
        logic [7:0] wdata;
        logic [8:0] line;
        logic [7:0] sprite_hits;
        logic [7:0] data_hits;
        logic [7:0] pen_x;
        logic [7:0] pen_y;
    } access_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
        logic       badline;
        logic [7:0] ctrl1;
        logic [7:0] ctrl2;
        logic [7:0] mptr;
    } status_t;

endpackage

// ===== design/vcrf_bank.sv =====
// Register state of the video chip register file with its read and write decode.
// Depends on vcrf_pkg; instantiated by video_chip_register_file.
module vcrf_bank #(
    parameter int FIRST_BAD_LINE = vcrf_pkg::FIRST_BAD_LINE_DEF,
    parameter int LAST_BAD_LINE  = vcrf_pkg::LAST_BAD_LINE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              acc_valid,
    input  vcrf_pkg::access_t acc,
    output vcrf_pkg::status_t status
);
    import vcrf_pkg::*;

    logic [7:0] spr_x_reg    [SPRITES];
    logic [7:0] spr_x_next   [SPRITES];
    logic [7:0] spr_y_reg    [SPRITES];
    logic [7:0] spr_y_next   [SPRITES];
    logic [3:0] shared_reg   [7];
    logic [3:0] shared_next  [7];
    logic [3:0] scolor_reg   [SPRITES];
    logic [3:0] scolor_next  [SPRITES];
    logic [7:0] xhi_reg, xhi_next;
    logic [7:0] ctrl1_reg, ctrl1_next;
    logic [7:0] ctrl2_reg, ctrl2_next;
    logic [7:0] spr_en_reg, spr_en_next;
    logic [7:0] yexp_reg, yexp_next;
    logic [7:0] mptr_reg, mptr_next;
    logic [7:0] flags_reg, flags_next;
    logic [3:0] mask_reg, mask_next;
    logic [7:0] prio_reg, prio_next;
    logic [7:0] mcol_reg, mcol_next;
    logic [7:0] xexp_reg, xexp_next;
    logic [7:0] scol_reg, scol_next;
    logic [7:0] dcol_reg, dcol_next;
    logic       written_reg, written_next;
    logic       allowed_reg, allowed_next;
    logic       bad_reg, bad_next;
    logic [7:0] rdata;

    logic [SPR_IDX_W-1:0] spr_idx;
    logic [2:0]           shared_idx;
    logic [SPR_IDX_W-1:0] scolor_idx;
    logic [5:0]           scolor_off;
    logic [7:0]           scol_hit;
    logic [7:0]           dcol_hit;
    logic                 in_window;

    assign spr_idx    = acc.addr[SPR_IDX_W:1];
    assign shared_idx = acc.addr[2:0];
    assign scolor_off = acc.addr - ADDR_SCOLOR_FIRST;
    assign scolor_idx = scolor_off[SPR_IDX_W-1:0];
    assign scol_hit   = scol_reg | acc.sprite_hits;
    assign dcol_hit   = dcol_reg | acc.data_hits;
    assign in_window  = (acc.line >= 9'(FIRST_BAD_LINE)) && (acc.line <= 9'(LAST_BAD_LINE));

    always_comb
    begin
        spr_x_next   = spr_x_reg;
        spr_y_next   = spr_y_reg;
        shared_next  = shared_reg;
        scolor_next  = scolor_reg;
        xhi_next     = xhi_reg;
        ctrl1_next   = ctrl1_reg;
        ctrl2_next   = ctrl2_reg;
        spr_en_next  = spr_en_reg;
        yexp_next    = yexp_reg;
        mptr_next    = mptr_reg;
        flags_next   = flags_reg;
        mask_next    = mask_reg;
        prio_next    = prio_reg;
        mcol_next    = mcol_reg;
        xexp_next    = xexp_reg;
        scol_next    = scol_reg;
        dcol_next    = dcol_reg;
        written_next = written_reg;
        allowed_next = allowed_reg;
        bad_next     = bad_reg;
        rdata        = 8'h00;
        if (acc_valid)
        begin
            // New collision bits land before the access, so a read sees them.
            scol_next = scol_hit;
            dcol_next = dcol_hit;
            if (acc.line == 9'd0)
            begin
                allowed_next = 1'b0;
            end
            if (acc.wr == CMD_WRITE)
            begin
                unique case (acc.addr) inside
                    [ADDR_SPR_FIRST:ADDR_SPR_LAST]:
                    begin
                        if (acc.addr[0])
                        begin
                            spr_y_next[spr_idx] = acc.wdata;
                        end
                        else
                        begin
                            spr_x_next[spr_idx] = acc.wdata;
                        end
                    end
                    [ADDR_SHARED_FIRST:ADDR_SHARED_LAST]: shared_next[shared_idx] = acc.wdata[3:0];
                    [ADDR_SCOLOR_FIRST:ADDR_SCOLOR_LAST]: scolor_next[scolor_idx] = acc.wdata[3:0];
                    ADDR_SPR_XHI: xhi_next = acc.wdata;
                    ADDR_CTRL1:
                    begin
                        ctrl1_next = acc.wdata;
                        if (acc.line == 9'(FIRST_BAD_LINE) && acc.wdata[4])
                        begin
                            allowed_next = 1'b1;
                        end
                        bad_next = in_window && (acc.wdata[2:0] == acc.line[2:0])
                                   && allowed_next;
                        written_next = 1'b1;
                    end
                    ADDR_SPR_EN:   spr_en_next = acc.wdata;
                    ADDR_CTRL2:    ctrl2_next  = acc.wdata;
                    ADDR_SPR_YEXP: yexp_next   = acc.wdata;
                    ADDR_MEM_PTR:  mptr_next   = acc.wdata;
                    ADDR_IRQ_FLAGS:
                    begin
                        // Writing a one acknowledges a source; the summary bit is rebuilt.
                        flags_next = {4'b0000, flags_reg[3:0] & ~acc.wdata[3:0]};
                        flags_next[7] = |(flags_next[3:0] & mask_reg);
                    end
                    ADDR_IRQ_MASK:
                    begin
                        mask_next = acc.wdata[3:0];
                        flags_next[7] = |(flags_reg[3:0] & acc.wdata[3:0]);
                    end
                    ADDR_SPR_PRIO: prio_next = acc.wdata;
                    ADDR_SPR_MCOL: mcol_next = acc.wdata;
                    ADDR_SPR_XEXP: xexp_next = acc.wdata;
                    default: ;
                endcase
            end
            else
            begin
                unique case (acc.addr) inside
                    [ADDR_SPR_FIRST:ADDR_SPR_LAST]:
                        rdata = acc.addr[0] ? spr_y_reg[spr_idx] : spr_x_reg[spr_idx];
                    [ADDR_SHARED_FIRST:ADDR_SHARED_LAST]: rdata = {4'hF, shared_reg[shared_idx]};
                    [ADDR_SCOLOR_FIRST:ADDR_SCOLOR_LAST]: rdata = {4'hF, scolor_reg[scolor_idx]};
                    ADDR_SPR_XHI:   rdata = xhi_reg;
                    ADDR_CTRL1:     rdata = written_reg ? {acc.line[8], ctrl1_reg[6:0]} : 8'h00;
                    ADDR_RASTER:    rdata = acc.line[7:0];
                    ADDR_PEN_X:     rdata = acc.pen_x;
                    ADDR_PEN_Y:     rdata = acc.pen_y;
                    ADDR_SPR_EN:    rdata = spr_en_reg;
                    ADDR_CTRL2:     rdata = ctrl2_reg | 8'hC0;
                    ADDR_SPR_YEXP:  rdata = yexp_reg;
                    ADDR_MEM_PTR:   rdata = mptr_reg | 8'h01;
                    ADDR_IRQ_FLAGS: rdata = flags_reg | 8'h70;
                    ADDR_IRQ_MASK:  rdata = {4'hF, mask_reg};
                    ADDR_SPR_PRIO:  rdata = prio_reg;
                    ADDR_SPR_MCOL:  rdata = mcol_reg;
                    ADDR_SPR_XEXP:  rdata = xexp_reg;
                    ADDR_SPR_SCOL:
                    begin
                        rdata     = scol_hit;
                        scol_next = 8'h00;
                    end
                    ADDR_SPR_DCOL:
                    begin
                        rdata     = dcol_hit;
                        dcol_next = 8'h00;
                    end
                    default: rdata = UNUSED_READ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SPRITES; i++)
            begin
                spr_x_reg[i]  <= 8'h00;
                spr_y_reg[i]  <= 8'h00;
                scolor_reg[i] <= 4'h0;
            end
            for (int i = 0; i < 7; i++)
            begin
                shared_reg[i] <= 4'h0;
            end
            xhi_reg     <= 8'h00;
            ctrl1_reg   <= 8'h00;
            ctrl2_reg   <= 8'h00;
            spr_en_reg  <= 8'h00;
            yexp_reg    <= 8'h00;
            mptr_reg    <= 8'h00;
            flags_reg   <= 8'h00;
            mask_reg    <= 4'h0;
            prio_reg    <= 8'h00;
            mcol_reg    <= 8'h00;
            xexp_reg    <= 8'h00;
            scol_reg    <= 8'h00;
            dcol_reg    <= 8'h00;
            written_reg <= 1'b0;
            allowed_reg <= 1'b0;
            bad_reg     <= 1'b0;
        end
        else
        begin
            spr_x_reg   <= spr_x_next;
            spr_y_reg   <= spr_y_next;
            scolor_reg  <= scolor_next;
            shared_reg  <= shared_next;
            xhi_reg     <= xhi_next;
            ctrl1_reg   <= ctrl1_next;
            ctrl2_reg   <= ctrl2_next;
            spr_en_reg  <= spr_en_next;
            yexp_reg    <= yexp_next;
            mptr_reg    <= mptr_next;
            flags_reg   <= flags_next;
            mask_reg    <= mask_next;
            prio_reg    <= prio_next;
            mcol_reg    <= mcol_next;
            xexp_reg    <= xexp_next;
            scol_reg    <= scol_next;
            dcol_reg    <= dcol_next;
            written_reg <= written_next;
            allowed_reg <= allowed_next;
            bad_reg     <= bad_next;
        end
    end

    assign status.rdata   = rdata;
    assign status.irq     = flags_next[7];
    assign status.badline = bad_next;
    assign status.ctrl1   = ctrl1_next;
    assign status.ctrl2   = ctrl2_next;
    assign status.mptr    = mptr_next;

endmodule

// ===== design/video_chip_register_file.sv =====
// Top level of the video chip register file: access register, register bank, result register.
// Depends on vcrf_pkg, vcrf_bank and video_chip_register_file_macros.svh.
//
//  channel   handshake        payload
//  access    start / busy     cmd, address, write_data, raster_line, sprite_hits,
//                             data_hits, pen_x, pen_y
//  result    done (strobe)    read_data, irq_line, badline, display_mode, row_select,
//                             column_select, display_enable, x_scroll, y_scroll,
//                             screen_base, charset_addr, bitmap_addr
//
// One access can be taken every clock; busy stays low.
// The access beat is held in the access register, then passes through the bank decode
// into the result register, from which the result beat is driven.
// Reset clears the valid, result and bank registers to zero, so no clearing pass follows it.
// The receiver takes each result beat in its strobe cycle and cannot stall.
`include "video_chip_register_file_macros.svh"

module video_chip_register_file #(
    parameter int FIRST_BAD_LINE = vcrf_pkg::FIRST_BAD_LINE_DEF,
    parameter int LAST_BAD_LINE  = vcrf_pkg::LAST_BAD_LINE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [5:0]  address,
    input  logic [7:0]  write_data,
    input  logic [8:0]  raster_line,
    input  logic [7:0]  sprite_hits,
    input  logic [7:0]  data_hits,
    input  logic [7:0]  pen_x,
    input  logic [7:0]  pen_y,
    output logic        done,
    output logic [7:0]  read_data,
    output logic        irq_line,
    output logic        badline,
    output logic [2:0]  display_mode,
    output logic        row_select,
    output logic        column_select,
    output logic        display_enable,
    output logic [2:0]  x_scroll,
    output logic [2:0]  y_scroll,
    output logic [13:0] screen_base,
    output logic [13:0] charset_addr,
    output logic [13:0] bitmap_addr
);
    import vcrf_pkg::*;

    access_t acc_reg;
    logic    acc_valid_reg;
    status_t bank_status;
    status_t res_reg;
    logic    done_reg;
    logic    accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
        end
        else
        begin
            acc_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_reg <= '{wr: cmd, addr: address, wdata: write_data, line: raster_line,
                         sprite_hits: sprite_hits, data_hits: data_hits,
                         pen_x: pen_x, pen_y: pen_y};
        end
    end

    vcrf_bank #(
        .FIRST_BAD_LINE(FIRST_BAD_LINE),
        .LAST_BAD_LINE (LAST_BAD_LINE)
    ) u_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc_valid(acc_valid_reg),
        .acc      (acc_reg),
        .status   (bank_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= acc_valid_reg;
            if (acc_valid_reg)
            begin
                res_reg <= bank_status;
            end
        end
    end

    assign done           = done_reg;
    assign read_data      = res_reg.rdata;
    assign irq_line       = res_reg.irq;
    assign badline        = res_reg.badline;
    assign display_mode   = {res_reg.ctrl1[6], res_reg.ctrl1[5], res_reg.ctrl2[4]};
    assign row_select     = res_reg.ctrl1[3];
    assign column_select  = res_reg.ctrl2[3];
    assign display_enable = res_reg.ctrl1[4];
    assign x_scroll       = res_reg.ctrl2[2:0];
    assign y_scroll       = res_reg.ctrl1[2:0];
    assign screen_base    = {res_reg.mptr[7:4], 10'b0};
    assign charset_addr   = {res_reg.mptr[3:1], 11'b0};
    assign bitmap_addr    = {res_reg.mptr[3], 13'b0};

    // Every accepted beat yields exactly one result beat, through the access and result registers.
    `VCRF_ASSERT_IMPLY(a_result_follows, clk, rst_n, accept, ##2 done, "access without result")
    `VCRF_ASSERT_IMPLY(a_no_spurious, clk, rst_n, done, $past(accept, 2), "result without access")
    // A write beat returns zero read data.
    `VCRF_ASSERT_NEXT(a_write_zero, clk, rst_n, acc_valid_reg && acc_reg.wr == CMD_WRITE,
        read_data == 8'h00, "write returned nonzero read data")
    // Bad-line status only moves on a control-one write.
    `VCRF_ASSERT_NEXT(a_badline_hold, clk, rst_n,
        acc_valid_reg && !(acc_reg.wr == CMD_WRITE && acc_reg.addr == ADDR_CTRL1),
        badline == $past(badline), "bad-line status moved without a control write")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for video_chip_register_file: directed and random bus accesses.
// Depends on vcrf_pkg and the video_chip_register_file RTL; results are predicted in place.
module tb_top;
    import vcrf_pkg::*;

    localparam logic [5:0] ADDR_UNUSED_FIRST = ADDR_SCOLOR_LAST + 6'd1;
    localparam logic [5:0] ADDR_UNUSED_LAST  = 6'h3F;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq_line;
        logic        badline;
        logic [2:0]  display_mode;
        logic        row_select;
        logic        column_select;
        logic        display_enable;
        logic [2:0]  x_scroll;
        logic [2:0]  y_scroll;
        logic [13:0] screen_base;
        logic [13:0] charset_addr;
        logic [13:0] bitmap_addr;
    } bus_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cmd = CMD_READ;
    logic [5:0]  address = '0;
    logic [7:0]  write_data = '0;
    logic [8:0]  raster_line = '0;
    logic [7:0]  sprite_hits = '0;
    logic [7:0]  data_hits = '0;
    logic [7:0]  pen_x = '0;
    logic [7:0]  pen_y = '0;
    logic        done;
    logic [7:0]  read_data;
    logic        irq_line;
    logic        badline;
    logic [2:0]  display_mode;
    logic        row_select;
    logic        column_select;
    logic        display_enable;
    logic [2:0]  x_scroll;
    logic [2:0]  y_scroll;
    logic [13:0] screen_base;
    logic [13:0] charset_addr;
    logic [13:0] bitmap_addr;

    // Shadow copy of the register bank.
    logic [8:0] pos_x [SPRITES] = '{default: '0};
    logic [7:0] pos_y [SPRITES] = '{default: '0};
    logic [7:0] pos_x_msb = '0;
    logic [7:0] ctrl_one = '0;
    logic [7:0] ctrl_two = '0;
    logic [8:0] line_compare = '0;
    logic [7:0] spr_enable = '0;
    logic [7:0] y_expand = '0;
    logic [7:0] y_expand_ff = 8'hFF;
    logic [7:0] mem_ptr = '0;
    logic [7:0] int_flags = '0;
    logic [3:0] int_mask = '0;
    logic [7:0] spr_prio = '0;
    logic [7:0] spr_mcol = '0;
    logic [7:0] x_expand = '0;
    logic [3:0] common_color [7] = '{default: '0};
    logic [3:0] spr_color [SPRITES] = '{default: '0};
    logic [7:0] spr_spr_latch = '0;
    logic [7:0] spr_bg_latch = '0;
    logic       ctrl_one_seen = 1'b0;
    logic       bad_enable = 1'b0;
    logic       bad_active = 1'b0;

    bus_reply_t pending_replies [$];
    bus_reply_t got_reply;
    bus_reply_t want_reply;
    int         mismatch_count = 0;
    int         reply_count = 0;
    int         quiet_run = 0;

    video_chip_register_file uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .address        (address),
        .write_data     (write_data),
        .raster_line    (raster_line),
        .sprite_hits    (sprite_hits),
        .data_hits      (data_hits),
        .pen_x          (pen_x),
        .pen_y          (pen_y),
        .done           (done),
        .read_data      (read_data),
        .irq_line       (irq_line),
        .badline        (badline),
        .display_mode   (display_mode),
        .row_select     (row_select),
        .column_select  (column_select),
        .display_enable (display_enable),
        .x_scroll       (x_scroll),
        .y_scroll       (y_scroll),
        .screen_base    (screen_base),
        .charset_addr   (charset_addr),
        .bitmap_addr    (bitmap_addr)
    );

    always #5 clk = ~clk;

    // Applies one access to the shadow bank and returns the reply it should produce.
    function automatic bus_reply_t predict_reply(access_t a);
        bus_reply_t           r;
        int                   idx;
        logic [SPR_IDX_W-1:0] sel;
        logic [2:0]           shared_sel;
        logic [7:0]           v;
        v = a.wdata;
        r = '0;
        sel = a.addr[SPR_IDX_W:1];
        shared_sel = 3'(a.addr - ADDR_SHARED_FIRST);
        spr_spr_latch = spr_spr_latch | a.sprite_hits;
        spr_bg_latch = spr_bg_latch | a.data_hits;
        if (a.line == 9'd0)
            bad_enable = 1'b0;
        if (a.wr == CMD_WRITE)
        begin
            if (a.addr <= ADDR_SPR_LAST)
            begin
                if (a.addr[0])
                    pos_y[sel] = v;
                else
                    pos_x[sel] = {pos_x[sel][8], v};
            end
            else if (a.addr >= ADDR_SHARED_FIRST && a.addr <= ADDR_SHARED_LAST)
                common_color[shared_sel] = v[3:0];
            else if (a.addr >= ADDR_SCOLOR_FIRST && a.addr <= ADDR_SCOLOR_LAST)
                spr_color[SPR_IDX_W'(a.addr - ADDR_SCOLOR_FIRST)] = v[3:0];
            else
            begin
                case (a.addr)
                    ADDR_SPR_XHI:
                    begin
                        pos_x_msb = v;
                        for (idx = 0; idx < SPRITES; idx++)
                            pos_x[idx][8] = v[idx];
                    end
                    ADDR_CTRL1:
                    begin
                        ctrl_one = v;
                        line_compare[8] = v[7];
                        if (a.line == FIRST_BAD_LINE_DEF && v[4])
                            bad_enable = 1'b1;
                        bad_active = a.line >= FIRST_BAD_LINE_DEF && a.line <= LAST_BAD_LINE_DEF
                                     && v[2:0] == a.line[2:0] && bad_enable;
                        ctrl_one_seen = 1'b1;
                    end
                    ADDR_RASTER:   line_compare[7:0] = v;
                    ADDR_SPR_EN:   spr_enable = v;
                    ADDR_CTRL2:    ctrl_two = v;
                    ADDR_SPR_YEXP:
                    begin
                        y_expand = v;
                        y_expand_ff = y_expand_ff | ~v;
                    end
                    ADDR_MEM_PTR:  mem_ptr = v;
                    ADDR_IRQ_FLAGS:
                    begin
                        int_flags = int_flags & (~v & 8'h0F);
                        if ((int_flags[3:0] & int_mask) != 4'd0)
                            int_flags[7] = 1'b1;
                    end
                    ADDR_IRQ_MASK:
                    begin
                        int_mask = v[3:0];
                        int_flags[7] = (int_flags[3:0] & int_mask) != 4'd0;
                    end
                    ADDR_SPR_PRIO: spr_prio = v;
                    ADDR_SPR_MCOL: spr_mcol = v;
                    ADDR_SPR_XEXP: x_expand = v;
                    default: ;
                endcase
            end
        end
        else
        begin
            if (a.addr <= ADDR_SPR_LAST)
                r.read_data = a.addr[0] ? pos_y[sel] : pos_x[sel][7:0];
            else if (a.addr >= ADDR_SHARED_FIRST && a.addr <= ADDR_SHARED_LAST)
                r.read_data = {4'hF, common_color[shared_sel]};
            else if (a.addr >= ADDR_SCOLOR_FIRST && a.addr <= ADDR_SCOLOR_LAST)
                r.read_data = {4'hF, spr_color[SPR_IDX_W'(a.addr - ADDR_SCOLOR_FIRST)]};
            else
            begin
                case (a.addr)
                    ADDR_SPR_XHI:   r.read_data = pos_x_msb;
                    ADDR_CTRL1:
                        r.read_data = ctrl_one_seen ? {a.line[8], ctrl_one[6:0]} : 8'h00;
                    ADDR_RASTER:    r.read_data = a.line[7:0];
                    ADDR_PEN_X:     r.read_data = a.pen_x;
                    ADDR_PEN_Y:     r.read_data = a.pen_y;
                    ADDR_SPR_EN:    r.read_data = spr_enable;
                    ADDR_CTRL2:     r.read_data = ctrl_two | 8'hC0;
                    ADDR_SPR_YEXP:  r.read_data = y_expand;
                    ADDR_MEM_PTR:   r.read_data = mem_ptr | 8'h01;
                    ADDR_IRQ_FLAGS: r.read_data = int_flags | 8'h70;
                    ADDR_IRQ_MASK:  r.read_data = {4'hF, int_mask};
                    ADDR_SPR_PRIO:  r.read_data = spr_prio;
                    ADDR_SPR_MCOL:  r.read_data = spr_mcol;
                    ADDR_SPR_XEXP:  r.read_data = x_expand;
                    ADDR_SPR_SCOL:
                    begin
                        r.read_data = spr_spr_latch;
                        spr_spr_latch = 8'h00;
                    end
                    ADDR_SPR_DCOL:
                    begin
                        r.read_data = spr_bg_latch;
                        spr_bg_latch = 8'h00;
                    end
                    default:        r.read_data = UNUSED_READ;
                endcase
            end
        end
        r.irq_line = int_flags[7];
        r.badline = bad_active;
        r.display_mode = {ctrl_one[6], ctrl_one[5], ctrl_two[4]};
        r.row_select = ctrl_one[3];
        r.column_select = ctrl_two[3];
        r.display_enable = ctrl_one[4];
        r.x_scroll = ctrl_two[2:0];
        r.y_scroll = ctrl_one[2:0];
        r.screen_base = {mem_ptr[7:4], 10'd0};
        r.charset_addr = {mem_ptr[3:1], 11'd0};
        r.bitmap_addr = {mem_ptr[3], 13'd0};
        return r;
    endfunction

    function automatic access_t quiet_access(logic wr, logic [5:0] addr, logic [7:0] wdata,
                                             logic [8:0] line);
        access_t a;
        a.wr = wr;
        a.addr = addr;
        a.wdata = wdata;
        a.line = line;
        a.sprite_hits = 8'h00;
        a.data_hits = 8'h00;
        a.pen_x = 8'($urandom);
        a.pen_y = 8'($urandom);
        return a;
    endfunction

    function automatic access_t random_access();
        access_t a;
        int      pick;
        a.wr = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick < 3)
            a.addr = 6'($urandom_range(0, 63));
        else if (pick < 6)
            a.addr = ADDR_SPR_XHI + 6'($urandom_range(0, 15));
        else if (pick < 8)
            a.addr = ADDR_CTRL1;
        else if (pick < 9)
            a.addr = $urandom_range(0, 1) ? ADDR_SPR_SCOL : ADDR_SPR_DCOL;
        else
            a.addr = ADDR_SHARED_FIRST + 6'($urandom_range(0, 14));
        pick = $urandom_range(0, 7);
        case (pick)
            0:       a.line = 9'd0;
            1:       a.line = 9'(FIRST_BAD_LINE_DEF);
            2:       a.line = 9'($urandom_range(FIRST_BAD_LINE_DEF, LAST_BAD_LINE_DEF));
            3:       a.line = 9'($urandom_range(0, 1) ? LAST_BAD_LINE_DEF
                                                      : LAST_BAD_LINE_DEF + 1);
            4:       a.line = 9'($urandom_range(0, 511));
            default: a.line = 9'($urandom_range(0, 311));
        endcase
        a.wdata = 8'($urandom);
        // Matching the fine scroll to the line makes bad lines reachable.
        if (a.addr == ADDR_CTRL1 && $urandom_range(0, 3) != 0)
            a.wdata[2:0] = a.line[2:0];
        a.sprite_hits = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
        a.data_hits = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
        a.pen_x = 8'($urandom);
        a.pen_y = 8'($urandom);
        return a;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch at result beat %0d, %s: got 0x%0h, expected 0x%0h",
                 reply_count, what, got, want);
        mismatch_count++;
    endtask

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_access(access_t a);
        int gap;
        if (quiet_run > 0)
        begin
            quiet_run--;
            gap = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            quiet_run = $urandom_range(4, 20);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= a.wr;
        address <= a.addr;
        write_data <= a.wdata;
        raster_line <= a.line;
        sprite_hits <= a.sprite_hits;
        data_hits <= a.data_hits;
        pen_x <= a.pen_x;
        pen_y <= a.pen_y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_replies.push_back(predict_reply(a));
    endtask

    task automatic wait_for_replies();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_reply.read_data = read_data;
            got_reply.irq_line = irq_line;
            got_reply.badline = badline;
            got_reply.display_mode = display_mode;
            got_reply.row_select = row_select;
            got_reply.column_select = column_select;
            got_reply.display_enable = display_enable;
            got_reply.x_scroll = x_scroll;
            got_reply.y_scroll = y_scroll;
            got_reply.screen_base = screen_base;
            got_reply.charset_addr = charset_addr;
            got_reply.bitmap_addr = bitmap_addr;
            if (pending_replies.size() == 0)
                report_mismatch("beat with nothing outstanding, read_data", read_data, 0);
            else
            begin
                want_reply = pending_replies.pop_front();
                if (got_reply.read_data !== want_reply.read_data)
                    report_mismatch("read_data", got_reply.read_data, want_reply.read_data);
                if (got_reply.irq_line !== want_reply.irq_line)
                    report_mismatch("irq_line", got_reply.irq_line, want_reply.irq_line);
                if (got_reply.badline !== want_reply.badline)
                    report_mismatch("badline", got_reply.badline, want_reply.badline);
                if (got_reply.display_mode !== want_reply.display_mode)
                    report_mismatch("display_mode", got_reply.display_mode,
                                    want_reply.display_mode);
                if (got_reply.row_select !== want_reply.row_select)
                    report_mismatch("row_select", got_reply.row_select, want_reply.row_select);
                if (got_reply.column_select !== want_reply.column_select)
                    report_mismatch("column_select", got_reply.column_select,
                                    want_reply.column_select);
                if (got_reply.display_enable !== want_reply.display_enable)
                    report_mismatch("display_enable", got_reply.display_enable,
                                    want_reply.display_enable);
                if (got_reply.x_scroll !== want_reply.x_scroll)
                    report_mismatch("x_scroll", got_reply.x_scroll, want_reply.x_scroll);
                if (got_reply.y_scroll !== want_reply.y_scroll)
                    report_mismatch("y_scroll", got_reply.y_scroll, want_reply.y_scroll);
                if (got_reply.screen_base !== want_reply.screen_base)
                    report_mismatch("screen_base", got_reply.screen_base,
                                    want_reply.screen_base);
                if (got_reply.charset_addr !== want_reply.charset_addr)
                    report_mismatch("charset_addr", got_reply.charset_addr,
                                    want_reply.charset_addr);
                if (got_reply.bitmap_addr !== want_reply.bitmap_addr)
                    report_mismatch("bitmap_addr", got_reply.bitmap_addr,
                                    want_reply.bitmap_addr);
            end
            reply_count++;
        end
    end

    task automatic test_reset_readback();
        // Control one reads as zero until it is first written, even with line bit 8 set.
        send_access(quiet_access(CMD_READ, ADDR_CTRL1, 8'h00, 9'd300));
        send_access(quiet_access(CMD_READ, ADDR_UNUSED_FIRST, 8'h00, 9'd0));
        send_access(quiet_access(CMD_READ, ADDR_UNUSED_LAST, 8'hFF, 9'd311));
    endtask

    task automatic test_sprite_position();
        send_access(quiet_access(CMD_WRITE, ADDR_SPR_FIRST, 8'hFF, 9'd10));
        send_access(quiet_access(CMD_WRITE, ADDR_SPR_XHI, 8'hFF, 9'd10));
        send_access(quiet_access(CMD_READ, ADDR_SPR_FIRST, 8'h00, 9'd10));
        send_access(quiet_access(CMD_READ, ADDR_SPR_XHI, 8'h00, 9'd10));
    endtask

    task automatic test_read_only_ports();
        access_t a;
        send_access(quiet_access(CMD_WRITE, ADDR_PEN_X, 8'h5A, 9'd20));
        a = quiet_access(CMD_READ, ADDR_PEN_X, 8'h00, 9'd20);
        a.pen_x = 8'hFF;
        send_access(a);
        a = quiet_access(CMD_READ, ADDR_PEN_Y, 8'h00, 9'd20);
        a.pen_y = 8'h00;
        send_access(a);
    endtask

    task automatic test_collision_latches();
        access_t a;
        a = quiet_access(CMD_READ, ADDR_SPR_SCOL, 8'h00, 9'd30);
        a.sprite_hits = 8'hFF;
        send_access(a);
        send_access(quiet_access(CMD_READ, ADDR_SPR_SCOL, 8'h00, 9'd30));
        // A write to a latch address is ignored, but the new bits still collect.
        a = quiet_access(CMD_WRITE, ADDR_SPR_DCOL, 8'hFF, 9'd30);
        a.data_hits = 8'h81;
        send_access(a);
        send_access(quiet_access(CMD_READ, ADDR_SPR_DCOL, 8'h00, 9'd30));
    endtask

    task automatic test_badline_enable();
        send_access(quiet_access(CMD_WRITE, ADDR_CTRL1, 8'h18, 9'(FIRST_BAD_LINE_DEF)));
        send_access(quiet_access(CMD_READ, ADDR_CTRL1, 8'h00, 9'd311));
        // Line zero withdraws the enable.
        send_access(quiet_access(CMD_WRITE, ADDR_CTRL1, 8'h10, 9'd0));
        send_access(quiet_access(CMD_WRITE, ADDR_CTRL1, 8'h1F, 9'(FIRST_BAD_LINE_DEF)));
        send_access(quiet_access(CMD_WRITE, ADDR_CTRL1, 8'hF7, 9'(LAST_BAD_LINE_DEF)));
        send_access(quiet_access(CMD_WRITE, ADDR_CTRL1, 8'h10, 9'(LAST_BAD_LINE_DEF + 1)));
    endtask

    task automatic test_control_fields();
        send_access(quiet_access(CMD_WRITE, ADDR_CTRL2, 8'hFF, 9'd100));
        send_access(quiet_access(CMD_WRITE, ADDR_MEM_PTR, 8'hFF, 9'd100));
        send_access(quiet_access(CMD_READ, ADDR_MEM_PTR, 8'h00, 9'd100));
        send_access(quiet_access(CMD_WRITE, ADDR_IRQ_MASK, 8'h0F, 9'd100));
        send_access(quiet_access(CMD_WRITE, ADDR_IRQ_FLAGS, 8'hFF, 9'd100));
        send_access(quiet_access(CMD_READ, ADDR_IRQ_FLAGS, 8'h00, 9'd100));
        send_access(quiet_access(CMD_WRITE, ADDR_SCOLOR_LAST, 8'hFF, 9'd100));
        send_access(quiet_access(CMD_READ, ADDR_SCOLOR_LAST, 8'h00, 9'd100));
    endtask

    // Arms bad lines at the first bad line, then walks through the bad-line window.
    task automatic run_badline_frame(output int items);
        access_t a;
        int      steps;
        int      k;
        a = random_access();
        a.wr = CMD_WRITE;
        a.addr = ADDR_CTRL1;
        a.line = 9'(FIRST_BAD_LINE_DEF);
        a.wdata[4] = 1'b1;
        a.wdata[2:0] = a.line[2:0];
        send_access(a);
        steps = $urandom_range(2, 6);
        for (k = 0; k < steps; k++)
        begin
            a = random_access();
            a.addr = ADDR_CTRL1;
            a.wr = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_WRITE;
            a.line = 9'($urandom_range(FIRST_BAD_LINE_DEF, LAST_BAD_LINE_DEF));
            if ($urandom_range(0, 3) != 0)
                a.wdata[2:0] = a.line[2:0];
            send_access(a);
        end
        items = steps + 1;
    endtask

    task automatic test_random_accesses(int count);
        int sent;
        int frame_items;
        logic paused;
        sent = 0;
        paused = 1'b0;
        while (sent < count)
        begin
            if (!paused && sent >= count / 2)
            begin
                wait_for_replies();
                paused = 1'b1;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                run_badline_frame(frame_items);
                sent += frame_items;
            end
            else
            begin
                send_access(random_access());
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_readback();
        test_sprite_position();
        test_read_only_ports();
        test_collision_latches();
        test_badline_enable();
        test_control_fields();
        test_random_accesses(500);
        wait_for_replies();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule
